/* hdl/pci_host_bridge_config_space_top_defines.svh */
// assertion macros for the host bridge configuration space
// used by pci_host_bridge_config_space_top, no other dependencies
`ifndef PCI_HOST_BRIDGE_CONFIG_SPACE_TOP_DEFINES_SVH
`define PCI_HOST_BRIDGE_CONFIG_SPACE_TOP_DEFINES_SVH

// implication checked every clock, off while reset is asserted
`define PHB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition that must never be seen outside reset
`define PHB_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

/* hdl/phb_pkg.sv */
// types, codes and register tables for the host bridge configuration space
// no dependencies
package phb_pkg;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_RESET = 2'd2;

	localparam logic [7:0] ADDR_CMD_LO = 8'h04;
	localparam logic [7:0] ADDR_CMD_HI = 8'h05;
	localparam logic [7:0] ADDR_STS_LO = 8'h06;
	localparam logic [7:0] ADDR_STS_HI = 8'h07;
	localparam logic [7:0] ADDR_PAM0   = 8'h59;
	localparam logic [7:0] ADDR_PAM1   = 8'h5A;
	localparam logic [7:0] ADDR_PAM6   = 8'h5F;

	localparam logic [19:0] BIOS_BASE     = 20'hF0000;
	localparam logic [16:0] BIOS_SIZE     = 17'h10000;
	localparam logic [19:0] SEG_BASE      = 20'hC0000;
	localparam logic [19:0] SEG_STEP_HALF = 20'h04000;
	localparam logic [16:0] SEG_SIZE      = 17'h04000;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] func;
		logic [7:0] reg_addr;
		logic [7:0] wdata;
	} req_t;

	typedef struct packed {
		logic [7:0]  rdata;
		logic        map_valid;
		logic [19:0] map_base;
		logic [16:0] map_size;
		logic        read_internal;
		logic        write_internal;
		logic        shadow_bios;
		logic        last;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SECOND
	} state_t;

	// power-on contents, used for any byte not yet written
	function automatic logic [7:0] phb_default(input logic [7:0] a);
		logic [7:0] d;
		d = 8'h00;
		case (a)
			8'h00: d = 8'h86;
			8'h01: d = 8'h80;
			8'h02: d = 8'h30;
			8'h03: d = 8'h70;
			8'h04: d = 8'h06;
			8'h07: d = 8'h02;
			8'h0B: d = 8'h06;
			8'h52: d = 8'h42;
			8'h53: d = 8'h14;
			8'h56: d = 8'h52;
			8'h57: d = 8'h01;
			8'h60, 8'h61, 8'h62, 8'h63, 8'h64: d = 8'h02;
			8'h67: d = 8'h11;
			8'h69: d = 8'h03;
			8'h70: d = 8'h20;
			8'h72: d = 8'h02;
			8'h74: d = 8'h0E;
			8'h78: d = 8'h23;
			default: d = 8'h00;
		endcase
		return d;
	endfunction

	// id, class and reserved window bytes ignore writes
	function automatic logic phb_writable(input logic [7:0] a);
		logic ro;
		ro = (a >= 8'h10 && a < 8'h4F) || a <= 8'h03 ||
			(a >= 8'h08 && a <= 8'h0C) || a == 8'h0E;
		return !ro;
	endfunction

	// command and status byte masking
	function automatic logic [7:0] phb_wmask(input logic [7:0] a, input logic [7:0] v);
		logic [7:0] m;
		m = v;
		if (a == ADDR_CMD_LO) begin
			m = (v & 8'h02) | 8'h04;
		end else if (a == ADDR_CMD_HI || a == ADDR_STS_LO) begin
			m = 8'h00;
		end else if (a == ADDR_STS_HI) begin
			m = (v & 8'h80) | 8'h02;
		end
		return m;
	endfunction

endpackage

/* hdl/pci_host_bridge_config_space_top.sv */
// host bridge pci configuration space: 256-byte register ram with pam decode
// depends on phb_pkg and pci_host_bridge_config_space_top_defines.svh
//
// usage
//  req channel (req_valid/req_ready/req): one beat per config read, config
//  write or bus reset. rsp channel (rsp_valid/rsp_ready/rsp): one or two beats
//  per request, the final one flagged by last.
//  a request passes through the register ram read, then the read-modify-write
//  that loads the response register. a pam write that changes both nibbles
//  adds a further step for its second beat. req_ready is high only between
//  requests, so a new request is not taken until the previous one has loaded
//  all its beats into the response register.
//  the response register holds a finished beat while the next request is
//  taken; if rsp_ready stays low the block stalls in its update step with
//  the ram untouched until the beat drains.
//  reset (arst_n low) restores the power-on register values through per-byte
//  valid flags, clears the bios shadow flag and empties the response register;
//  no clearing pass is needed, requests are taken as soon as reset is released.
`include "pci_host_bridge_config_space_top_defines.svh"

module pci_host_bridge_config_space_top
	import phb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	state_t state_q, state_d;

	logic [7:0] mem [256];
	logic [255:0] vld_q;
	logic [7:0] mem_s1;
	logic vld_s1;
	req_t req_q;
	logic flag_q;
	rsp_t rsp_q;
	logic rsp_valid_q;
	rsp_t pend_s2;

	logic req_fire, out_free, exec_go, second_go;
	logic [7:0] rd_addr;
	logic [7:0] old_b, eaddr, ev, v, diff;
	logic wr, chg0, lo, hi, two, flag_new;
	logic [2:0] pam_n;
	logic [19:0] base_lo, base_hi;
	rsp_t res1, res2;

	assign req_fire = req_valid && req_ready;
	assign out_free = !rsp_valid_q || rsp_ready;
	assign rd_addr  = (req.kind == KIND_RESET) ? ADDR_PAM0 : req.reg_addr;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) state_d = two ? ST_SECOND : ST_IDLE;
			end
			ST_SECOND: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		req_ready = 1'b0;
		exec_go   = 1'b0;
		second_go = 1'b0;
		unique case (state_q)
			ST_IDLE:   req_ready = 1'b1;
			ST_EXEC:   exec_go   = out_free;
			ST_SECOND: second_go = out_free;
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// register ram, read data registered
	always_ff @(posedge clk) begin
		if (req_fire) begin
			mem_s1 <= mem[rd_addr];
		end
		if (exec_go && wr) begin
			mem[eaddr] <= v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
			flag_q <= 1'b0;
		end else begin
			if (req_fire) vld_s1 <= vld_q[rd_addr];
			if (exec_go && wr) vld_q[eaddr] <= 1'b1;
			if (exec_go) flag_q <= flag_new;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) req_q <= req;
	end

	// update step
	always_comb begin
		old_b = vld_s1 ? mem_s1 : phb_default(req_q.reg_addr);
		if (req_q.kind == KIND_RESET) begin
			old_b = vld_s1 ? mem_s1 : phb_default(ADDR_PAM0);
		end
		eaddr = (req_q.kind == KIND_RESET) ? ADDR_PAM0 : req_q.reg_addr;
		ev    = (req_q.kind == KIND_RESET) ? 8'h00 : req_q.wdata;
		wr    = ((req_q.kind == KIND_WRITE && req_q.func == 3'd0) ||
			req_q.kind == KIND_RESET) && phb_writable(eaddr);
		v     = phb_wmask(eaddr, ev);
		diff  = old_b ^ v;
		chg0  = wr && eaddr == ADDR_PAM0 && (|diff[7:4]);
		lo    = wr && eaddr >= ADDR_PAM1 && eaddr <= ADDR_PAM6 && (|diff[3:0]);
		hi    = wr && eaddr >= ADDR_PAM1 && eaddr <= ADDR_PAM6 && (|diff[7:4]);
		two   = lo && hi;
		flag_new = chg0 ? v[4] : flag_q;
		pam_n   = eaddr[2:0] - 3'd2;
		base_lo = SEG_BASE + {2'b00, pam_n, 15'b0};
		base_hi = base_lo + SEG_STEP_HALF;

		res1 = '0;
		res1.shadow_bios = flag_new;
		res1.last = 1'b1;
		if (req_q.kind == KIND_READ) begin
			res1.rdata = (req_q.func != 3'd0) ? 8'hFF : old_b;
		end
		if (chg0) begin
			res1.map_valid      = 1'b1;
			res1.map_base       = BIOS_BASE;
			res1.map_size       = BIOS_SIZE;
			res1.read_internal  = v[4];
			res1.write_internal = v[5];
		end else if (lo) begin
			res1.map_valid      = 1'b1;
			res1.map_base       = base_lo;
			res1.map_size       = SEG_SIZE;
			res1.read_internal  = v[0];
			res1.write_internal = v[1];
			res1.last           = !hi;
		end else if (hi) begin
			res1.map_valid      = 1'b1;
			res1.map_base       = base_hi;
			res1.map_size       = SEG_SIZE;
			res1.read_internal  = v[4];
			res1.write_internal = v[5];
		end

		res2 = '0;
		res2.map_valid      = 1'b1;
		res2.map_base       = base_hi;
		res2.map_size       = SEG_SIZE;
		res2.read_internal  = v[4];
		res2.write_internal = v[5];
		res2.shadow_bios    = flag_new;
		res2.last           = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			pend_s2 <= res2;
			rsp_q   <= res1;
		end else if (second_go) begin
			rsp_q <= pend_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (exec_go || second_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`PHB_ASSERT_IMPL(a_second_beat_pending, clk, arst_n, state_q == ST_SECOND, rsp_valid_q && !rsp_q.last, "first pam beat missing while second is pending")
	`PHB_ASSERT_NEVER(a_idle_with_partial, clk, arst_n, req_ready && rsp_valid_q && !rsp_q.last, "new request taken before all beats were produced")
	`PHB_ASSERT_IMPL(a_bios_region, clk, arst_n, rsp_valid_q && rsp_q.map_valid && rsp_q.map_size == BIOS_SIZE, rsp_q.map_base == BIOS_BASE, "64k region reported at wrong base")

endmodule
